// ----- hdl/chm_pkg.sv -----
`default_nettype none
package chm_pkg;

	localparam int BUCKETS  = 1024;
	localparam int ENTRIES  = 256;
	localparam int KEY_BITS = 32;
	localparam int Q_DEPTH  = 2;

	localparam int BKT_W   = $clog2(BUCKETS);
	localparam int BCNT_W  = BKT_W + 1;
	localparam int ENT_W   = $clog2(ENTRIES);
	localparam int LINK_W  = ENT_W + 1;
	localparam int CNT_W   = ENT_W + 1;
	localparam int HKEY_W  = KEY_BITS - 2;
	localparam int STEP_W  = $clog2(HKEY_W);

	localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(ENTRIES);
	localparam logic [BCNT_W-1:0] BCOUNT_RESET = BCNT_W'(509);

	localparam logic [1:0] OP_GET    = 2'd0;
	localparam logic [1:0] OP_PUT    = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;

	typedef struct packed {
		logic [1:0]          opcode;
		logic [KEY_BITS-1:0] key;
		logic [31:0]         value;
	} in_item_t;

	typedef struct packed {
		logic             found;
		logic [31:0]      old_value;
		logic             status;
		logic [CNT_W-1:0] entry_count;
	} out_item_t;

	typedef struct packed {
		logic [1:0]          opcode;
		logic [KEY_BITS-1:0] key;
		logic [31:0]         value;
		logic [BKT_W-1:0]    bucket;
	} job_t;

	typedef struct packed {
		logic clearing;
		logic busy;
	} back_stat_t;

endpackage
`default_nettype wire

// ----- hdl/chained_hash_map_core.sv -----
// channel | dir | handshake              | beat
// in      | in  | in_valid / in_ready    | in_item_t: opcode, key, value
// out     | out | out_valid / out_ready  | out_item_t: found, old_value, status, entry_count
// cfg     | in  | psel/penable/pwrite    | bucket_count at byte address 0
// Front: one-bit remainder steps for (key >> 2) mod bucket_count (clamped to 1..1024).
// Back: S_HEAD, then S_LOOK and S_CMP for each chain entry visited, then S_ACT,
// plus S_ALLOC when reusing a freed entry, then the result beat.
// Front and back overlap: the front can take a new item while the back works on the last.
// Reset and every bucket_count write sweep the 1024-entry bucket table with in_ready
// low. out_ready low holds the result; up to three more items are taken, two queued
// and one held in the front.
`default_nettype none
module chained_hash_map_core import chm_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_data,
	input  wire logic      psel,
	input  wire logic      penable,
	input  wire logic      pwrite,
	input  wire logic [2:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);

	logic [BCNT_W-1:0] bcount_q;
	logic              cfg_wr;
	logic              q_wr;
	logic              q_full;
	logic              q_rd;
	logic              q_valid;
	job_t              q_wjob;
	job_t              q_rjob;
	back_stat_t        stat;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && !paddr[2];
	assign prdata = paddr[2] ? '0 : {{(32-BCNT_W){1'b0}}, bcount_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcount_q <= BCOUNT_RESET;
		end else if (cfg_wr) begin
			bcount_q <= pwdata[BCNT_W-1:0];
		end
	end

	chm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_data      (in_data),
		.bucket_count (bcount_q),
		.stat         (stat),
		.q_wr         (q_wr),
		.q_job        (q_wjob),
		.q_full       (q_full)
	);

	chm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (q_wr),
		.wr_job   (q_wjob),
		.full     (q_full),
		.rd       (q_rd),
		.rd_valid (q_valid),
		.rd_job   (q_rjob)
	);

	chm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_clear (cfg_wr),
		.q_valid   (q_valid),
		.q_job     (q_rjob),
		.q_rd      (q_rd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.stat      (stat)
	);

endmodule
`default_nettype wire

// ----- hdl/chm_front.sv -----
`default_nettype none
module chm_front import chm_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire in_item_t          in_data,
	input  wire logic [BCNT_W-1:0] bucket_count,
	input  wire back_stat_t        stat,
	output logic                   q_wr,
	output job_t                   q_job,
	input  wire logic              q_full
);

	logic                busy_q;
	logic                pend_q;
	logic [1:0]          op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [31:0]         val_q;
	logic [HKEY_W-1:0]   hkey_q;
	logic [BKT_W-1:0]    rem_q;
	logic [STEP_W-1:0]   cnt_q;
	logic [BCNT_W-1:0]   n;
	logic [BCNT_W-1:0]   t;

	always_comb begin
		if (bucket_count == '0) begin
			n = BCNT_W'(1);
		end else if (bucket_count > BCNT_W'(BUCKETS)) begin
			n = BCNT_W'(BUCKETS);
		end else begin
			n = bucket_count;
		end
	end

	assign t        = {rem_q, hkey_q[HKEY_W-1]};
	assign in_ready = !busy_q && !stat.clearing;
	assign q_wr     = busy_q && pend_q && !q_full;
	assign q_job    = '{opcode: op_q, key: key_q, value: val_q, bucket: rem_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pend_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			busy_q <= 1'b1;
			pend_q <= 1'b0;
		end else if (busy_q && !pend_q) begin
			if (cnt_q == STEP_W'(HKEY_W - 1)) begin
				pend_q <= 1'b1;
			end
		end else if (q_wr) begin
			busy_q <= 1'b0;
			pend_q <= 1'b0;
		end
	end

	// restoring remainder, one key bit a cycle
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q   <= in_data.opcode;
			key_q  <= in_data.key;
			val_q  <= in_data.value;
			hkey_q <= in_data.key[KEY_BITS-1:2];
			rem_q  <= '0;
			cnt_q  <= '0;
		end else if (busy_q && !pend_q) begin
			hkey_q <= {hkey_q[HKEY_W-2:0], 1'b0};
			cnt_q  <= cnt_q + STEP_W'(1);
			if (t >= n) begin
				rem_q <= BKT_W'(t - n);
			end else begin
				rem_q <= BKT_W'(t);
			end
		end
	end

endmodule
`default_nettype wire

// ----- hdl/chm_queue.sv -----
`default_nettype none
module chm_queue import chm_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr,
	input  wire job_t wr_job,
	output logic      full,
	input  wire logic rd,
	output logic      rd_valid,
	output job_t      rd_job
);

	localparam int PTR_W = $clog2(Q_DEPTH);

	job_t               mem_q [Q_DEPTH];
	logic [PTR_W-1:0]   wp_q;
	logic [PTR_W-1:0]   rp_q;
	logic [PTR_W:0]     cnt_q;

	assign full     = cnt_q == (PTR_W+1)'(Q_DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_job   = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= (wp_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wp_q + PTR_W'(1);
			end
			if (rd) begin
				rp_q <= (rp_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rp_q + PTR_W'(1);
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + (PTR_W+1)'(1);
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - (PTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wr_job;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/chm_back.sv -----
`default_nettype none
module chm_back import chm_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_clear,
	input  wire logic q_valid,
	input  wire job_t q_job,
	output logic      q_rd,
	output logic      out_valid,
	input  wire logic out_ready,
	output out_item_t out_data,
	output back_stat_t stat
);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_HEAD  = 3'd2;
	localparam logic [2:0] S_LOOK  = 3'd3;
	localparam logic [2:0] S_CMP   = 3'd4;
	localparam logic [2:0] S_ACT   = 3'd5;
	localparam logic [2:0] S_ALLOC = 3'd6;

	logic [LINK_W-1:0]   heads_q  [BUCKETS];
	logic [KEY_BITS-1:0] keys_q   [ENTRIES];
	logic [31:0]         vals_q   [ENTRIES];
	logic [LINK_W-1:0]   links_q  [ENTRIES];
	logic [ENT_W-1:0]    fstack_q [ENTRIES];

	logic [2:0]          state_q;
	logic [BKT_W-1:0]    clr_q;
	job_t                job_q;
	logic [LINK_W-1:0]   head_rd_q;
	logic [KEY_BITS-1:0] key_rd_q;
	logic [31:0]         val_rd_q;
	logic [LINK_W-1:0]   link_rd_q;
	logic [ENT_W-1:0]    fs_rd_q;
	logic [LINK_W-1:0]   head_q;
	logic [LINK_W-1:0]   cur_q;
	logic [LINK_W-1:0]   prev_q;
	logic [LINK_W-1:0]   next_q;
	logic [ENT_W-1:0]    steps_q;
	logic                found_q;
	logic [31:0]         old_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    fresh_q;
	logic [CNT_W-1:0]    stack_q;
	logic                out_valid_q;
	out_item_t           out_q;

	logic [BKT_W-1:0]  head_raddr;
	logic              head_we;
	logic [BKT_W-1:0]  head_waddr;
	logic [LINK_W-1:0] head_wdata;
	logic              key_we;
	logic              val_we;
	logic [ENT_W-1:0]  val_waddr;
	logic              link_we;
	logic [ENT_W-1:0]  link_waddr;
	logic [LINK_W-1:0] link_wdata;
	logic              fs_we;
	logic              ins;
	logic [ENT_W-1:0]  ins_idx;
	logic              rem_do;
	logic              full_refuse;
	logic              need_pop;
	logic              finish;
	logic [CNT_W-1:0]  count_nx;

	assign out_valid     = out_valid_q;
	assign out_data      = out_q;
	assign stat.clearing = state_q == S_CLEAR;
	assign stat.busy     = state_q != S_IDLE;
	assign q_rd          = state_q == S_IDLE && q_valid && !out_valid_q && !cfg_clear;
	assign head_raddr    = q_job.bucket;

	always_comb begin
		ins         = 1'b0;
		ins_idx     = fresh_q[ENT_W-1:0];
		rem_do      = 1'b0;
		full_refuse = 1'b0;
		need_pop    = 1'b0;
		finish      = 1'b0;
		head_we     = 1'b0;
		head_waddr  = job_q.bucket;
		head_wdata  = NIL_LINK;
		key_we      = 1'b0;
		val_we      = 1'b0;
		val_waddr   = cur_q[ENT_W-1:0];
		link_we     = 1'b0;
		link_waddr  = prev_q[ENT_W-1:0];
		link_wdata  = next_q;
		fs_we       = 1'b0;
		case (state_q)
			S_CLEAR: begin
				head_we    = 1'b1;
				head_waddr = clr_q;
			end
			S_ACT: begin
				finish = 1'b1;
				if (job_q.opcode == OP_PUT) begin
					if (found_q) begin
						val_we = 1'b1;
					end else if (count_q == CNT_W'(ENTRIES)) begin
						full_refuse = 1'b1;
					end else if (stack_q != '0) begin
						need_pop = 1'b1;
						finish   = 1'b0;
					end else begin
						ins = 1'b1;
					end
				end else if (job_q.opcode == OP_REMOVE && found_q) begin
					rem_do = 1'b1;
					fs_we  = 1'b1;
					if (prev_q == NIL_LINK) begin
						head_we    = 1'b1;
						head_wdata = next_q;
					end else begin
						link_we = 1'b1;
					end
				end
			end
			S_ALLOC: begin
				finish  = 1'b1;
				ins     = 1'b1;
				ins_idx = fs_rd_q;
			end
			default: begin
			end
		endcase
		if (ins) begin
			key_we     = 1'b1;
			val_we     = 1'b1;
			val_waddr  = ins_idx;
			link_we    = 1'b1;
			link_waddr = ins_idx;
			link_wdata = head_q;
			head_we    = 1'b1;
			head_wdata = {1'b0, ins_idx};
		end
		count_nx = count_q + CNT_W'(ins) - CNT_W'(rem_do);
	end

	always_ff @(posedge clk) begin
		head_rd_q <= heads_q[head_raddr];
		key_rd_q  <= keys_q[cur_q[ENT_W-1:0]];
		val_rd_q  <= vals_q[cur_q[ENT_W-1:0]];
		link_rd_q <= links_q[cur_q[ENT_W-1:0]];
		fs_rd_q   <= fstack_q[ENT_W'(stack_q - CNT_W'(1))];
		if (head_we) begin
			heads_q[head_waddr] <= head_wdata;
		end
		if (key_we) begin
			keys_q[ins_idx] <= job_q.key;
		end
		if (val_we) begin
			vals_q[val_waddr] <= job_q.value;
		end
		if (link_we) begin
			links_q[link_waddr] <= link_wdata;
		end
		if (fs_we) begin
			fstack_q[stack_q[ENT_W-1:0]] <= cur_q[ENT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			job_q <= q_job;
		end
		case (state_q)
			S_HEAD: begin
				head_q  <= head_rd_q;
				cur_q   <= head_rd_q;
				prev_q  <= NIL_LINK;
				steps_q <= '0;
				found_q <= 1'b0;
				old_q   <= '0;
			end
			S_CMP: begin
				if (key_rd_q == job_q.key) begin
					found_q <= 1'b1;
					old_q   <= val_rd_q;
					next_q  <= link_rd_q;
				end else begin
					prev_q  <= cur_q;
					cur_q   <= link_rd_q;
					steps_q <= steps_q + ENT_W'(1);
				end
			end
			default: begin
			end
		endcase
		if (finish) begin
			out_q.found       <= found_q;
			out_q.old_value   <= old_q;
			out_q.status      <= full_refuse;
			out_q.entry_count <= count_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			count_q     <= '0;
			fresh_q     <= '0;
			stack_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (cfg_clear) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			count_q <= '0;
			fresh_q <= '0;
			stack_q <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end
			count_q <= count_nx;
			if (ins && state_q == S_ACT) begin
				fresh_q <= fresh_q + CNT_W'(1);
			end
			if (state_q == S_ALLOC) begin
				stack_q <= stack_q - CNT_W'(1);
			end else if (fs_we) begin
				stack_q <= stack_q + CNT_W'(1);
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + BKT_W'(1);
					if (clr_q == BKT_W'(BUCKETS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (q_rd) begin
						state_q <= S_HEAD;
					end
				end
				S_HEAD: state_q <= S_LOOK;
				S_LOOK: state_q <= (cur_q == NIL_LINK) ? S_ACT : S_CMP;
				S_CMP: begin
					if (key_rd_q == job_q.key || steps_q == ENT_W'(ENTRIES - 1)) begin
						state_q <= S_ACT;
					end else begin
						state_q <= S_LOOK;
					end
				end
				S_ACT: state_q <= need_pop ? S_ALLOC : S_IDLE;
				S_ALLOC: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ENTRIES))
		else $error("binding count above pool size");

	a_pool_balance: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, stack_q} + {1'b0, count_q}) == {1'b0, fresh_q})
		else $error("free stack and bindings do not cover used entries");

	a_start_order: assert property (@(posedge clk) disable iff (!arst_n)
		q_rd |=> state_q == S_HEAD && !out_valid_q)
		else $error("job started while a result was pending");

endmodule
`default_nettype wire

// ----- tb/sv/chained_hash_map_core_test.sv -----
`default_nettype none
module chained_hash_map_core_test;
	import chm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_data;
	logic out_valid;
	logic out_ready;
	out_item_t out_data;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	chained_hash_map_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// map mirror
	int unsigned bcount;
	logic [LINK_W-1:0] heads [BUCKETS];
	logic [KEY_BITS-1:0] ekey [ENTRIES];
	logic [31:0] eval [ENTRIES];
	logic [LINK_W-1:0] elink [ENTRIES];
	logic [ENT_W-1:0] free_list [ENTRIES];
	int unsigned free_top;
	int unsigned bindings;

	out_item_t pending_results[$];
	int mismatches;
	int stall_cycles;
	int send_idle_pct;
	int recv_idle_pct;
	logic [KEY_BITS-1:0] key_pool [$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void clear_mirror();
		for (int i = 0; i < BUCKETS; i++) heads[i] = NIL_LINK;
		for (int i = 0; i < ENTRIES; i++) begin
			elink[i] = NIL_LINK;
			free_list[i] = ENT_W'(i);
		end
		free_top = ENTRIES;
		bindings = 0;
	endfunction

	function automatic out_item_t apply_op(in_item_t it);
		out_item_t r;
		int unsigned n;
		int unsigned b;
		int unsigned prev;
		int unsigned cur;
		int unsigned e;
		int steps;
		bit hit;
		n = bcount;
		if (n == 0) n = 1;
		if (n > BUCKETS) n = BUCKETS;
		b = (it.key >> 2) % n;
		prev = ENTRIES;
		cur = heads[b];
		steps = 0;
		hit = 0;
		r = '0;
		while (cur < ENTRIES && steps < ENTRIES) begin
			if (ekey[cur] == it.key) begin
				hit = 1;
				break;
			end
			prev = cur;
			cur = elink[cur];
			steps++;
		end
		if (hit) r.old_value = eval[cur];
		r.found = hit;
		if (it.opcode == OP_PUT) begin
			if (hit) eval[cur] = it.value;
			else if (free_top == 0) r.status = 1'b1;
			else begin
				free_top--;
				e = free_list[free_top];
				ekey[e] = it.key;
				eval[e] = it.value;
				elink[e] = heads[b];
				heads[b] = LINK_W'(e);
				bindings++;
			end
		end else if (it.opcode == OP_REMOVE && hit) begin
			if (prev < ENTRIES) elink[prev] = elink[cur];
			else heads[b] = elink[cur];
			if (free_top < ENTRIES) begin
				free_list[free_top] = ENT_W'(cur);
				free_top++;
			end
			if (bindings > 0) bindings--;
		end
		r.entry_count = CNT_W'(bindings);
		return r;
	endfunction

	task automatic send_op(logic [1:0] op, logic [KEY_BITS-1:0] k, logic [31:0] v);
		in_item_t it;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		it.opcode = op;
		it.key = k;
		it.value = v;
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_results.push_back(apply_op(it));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_bucket_count(int unsigned n);
		drain();
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= '0;
		pwdata <= n;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		bcount = n & 32'h7FF;
		clear_mirror();
		key_pool.delete();
	endtask

	function automatic logic [KEY_BITS-1:0] pick_key();
		logic [KEY_BITS-1:0] k;
		if (key_pool.size() != 0 && $urandom_range(3) != 0)
			return key_pool[$urandom_range(key_pool.size() - 1)];
		case ($urandom_range(2))
			0: k = $urandom_range(4096);
			1: k = (32'($urandom_range(63)) << 2) | 32'($urandom_range(3));
			default: k = $urandom;
		endcase
		if (key_pool.size() < 400) key_pool.push_back(k);
		return k;
	endfunction

	task automatic test_directed();
		send_op(OP_GET, 32'h0, 32'h0);
		send_op(OP_PUT, 32'h0, 32'h0);
		send_op(OP_GET, 32'h0, 32'h1);
		send_op(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_op(OP_PUT, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
		send_op(OP_PUT, 32'd4, 32'h1111);
		send_op(OP_PUT, 32'd4 + 509*4, 32'h2222);
		send_op(OP_PUT, 32'd4 + 2*509*4, 32'h3333);
		send_op(OP_REMOVE, 32'd4 + 509*4, 32'h0);
		send_op(OP_GET, 32'd4, 32'h0);
		send_op(OP_GET, 32'd4 + 2*509*4, 32'h0);
		send_op(OP_REMOVE, 32'd4 + 509*4, 32'h0);
		send_op(2'd3, 32'd4, 32'hDEAD);
		send_op(OP_REMOVE, 32'h0, 32'h0);
		send_op(OP_GET, 32'h0, 32'h0);
	endtask

	task automatic test_pool_full();
		write_bucket_count(1);
		for (int i = 0; i < ENTRIES + 3; i++) send_op(OP_PUT, $urandom, $urandom);
		send_op(OP_PUT, 32'h0, 32'h0);
		send_op(OP_REMOVE, ekey[0], 32'h0);
		send_op(OP_PUT, 32'h1234_5678, 32'h9);
		send_op(OP_GET, 32'h1234_5678, 32'h0);
	endtask

	task automatic test_random(int n_items, int unsigned n_buckets);
		logic [1:0] op;
		write_bucket_count(n_buckets);
		for (int i = 0; i < n_items; i++) begin
			case ($urandom_range(9))
				0, 1, 2, 3: op = OP_PUT;
				4, 5, 6: op = OP_GET;
				7, 8: op = OP_REMOVE;
				default: op = 2'd3;
			endcase
			send_op(op, pick_key(), $urandom);
		end
	endtask

	always @(posedge clk) begin
		if ($urandom_range(99) < recv_idle_pct) out_ready <= 1'b0;
		else out_ready <= 1'b1;
		if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected beat %p", out_data);
			end else begin
				if (out_data !== pending_results[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp %p act %p", pending_results[0], out_data);
				end
				void'(pending_results.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || psel) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		mismatches = 0;
		stall_cycles = 0;
		send_idle_pct = 7;
		recv_idle_pct = 53;
		bcount = 509;
		clear_mirror();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_pool_full();
		test_random(350, 1024);
		send_idle_pct = 53;
		recv_idle_pct = 7;
		test_random(300, 0);
		test_random(300, 2047);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(250, 7);
		test_random(220, 509);
		drain();
		if (mismatches == 0 && pending_results.size() == 0) $display("SCOREBOARD CLEAN");
		else $display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
`default_nettype wire
